/* hdl/ssc_pkg.sv */
`default_nettype none

package ssc_pkg;

    // Default geometry and motor parameters
    localparam int COLS_DEF         = 16;
    localparam int ROWS_DEF         = 2;
    localparam int SETPOINT_MAX_DEF = 5;
    localparam int PHASE_COUNT_DEF  = 4;

    // Storage widths, sized for the widest parameter settings
    localparam int COL_W      = 6;
    localparam int ROW_W      = 3;
    localparam int PH_W       = 3;
    localparam int VOLT_W     = 3;
    localparam int DB_W       = 16;
    localparam int LEAN_W     = 8;
    localparam int TOL_W      = 16;
    localparam int LIGHT_W    = 12;
    localparam int SCALED_W   = 18;
    localparam int ERR_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Hot spots on the menu screen
    localparam int MODE_COL = 7;
    localparam int MODE_ROW = 1;
    localparam int ADJ_COL  = 9;
    localparam int ADJ_ROW  = 0;

    // Light error scaling: 40920 per setpoint volt, 50 per photocell count
    localparam logic [15:0] VOLT_SCALE  = 16'd40920;
    localparam logic [5:0]  LIGHT_SCALE = 6'd50;

    // Register reset values
    localparam logic [DB_W-1:0]   DEBOUNCE_RST  = 16'd500;
    localparam logic [LEAN_W-1:0] HIGH_LEAN_RST = 8'd192;
    localparam logic [LEAN_W-1:0] LOW_LEAN_RST  = 8'd64;
    localparam logic [TOL_W-1:0]  TOL_RST       = 16'd4092;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS  = 3'd0,
        REG_HIGH_LEAN       = 3'd1,
        REG_LOW_LEAN        = 3'd2,
        REG_ERROR_TOLERANCE = 3'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SCR_MENU = 3'b001,
        SCR_JOG  = 3'b010,
        SCR_EDIT = 3'b100
    } screen_t;

    // Screen codes as reported on the result port
    localparam logic [1:0] SCREEN_CODE_MENU = 2'd0;
    localparam logic [1:0] SCREEN_CODE_JOG  = 2'd1;
    localparam logic [1:0] SCREEN_CODE_EDIT = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         joy_x;
        logic [7:0]         joy_y;
        logic [7:0]         click_level;
        logic [LIGHT_W-1:0] light_sum;
        logic               light_valid;
    } item_t;

    typedef struct packed {
        logic [DB_W-1:0]   debounce_ticks;
        logic [LEAN_W-1:0] high_lean;
        logic [LEAN_W-1:0] low_lean;
        logic [TOL_W-1:0]  error_tolerance;
    } cfg_t;

    typedef struct packed {
        screen_t             screen;
        logic                auto_mode;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [VOLT_W-1:0]   target;
        logic [DB_W-1:0]     db_count;
        logic [PH_W-1:0]     phase;
        logic                coil_on;
        logic [SCALED_W-1:0] light_scaled;
    } state_t;

    typedef struct packed {
        logic stepped;
        logic moved;
        logic clr;
    } flags_t;

    typedef struct packed {
        logic step_req;
        logic step_up;
    } auto_t;

    function automatic logic [1:0] screen_code(input screen_t scr);
        logic [1:0] code;
        unique case (scr)
            SCR_MENU: code = SCREEN_CODE_MENU;
            SCR_JOG:  code = SCREEN_CODE_JOG;
            SCR_EDIT: code = SCREEN_CODE_EDIT;
            default:  code = SCREEN_CODE_MENU;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* hdl/ssc_auto.sv */
`default_nettype none

module ssc_auto (
    input  wire logic [ssc_pkg::VOLT_W-1:0]   target,
    input  wire logic [ssc_pkg::SCALED_W-1:0] light_scaled,
    input  wire logic [ssc_pkg::TOL_W-1:0]    error_tolerance,
    output ssc_pkg::auto_t                    auto_o
);

    logic [ssc_pkg::ERR_W-1:0] target_term;
    logic [ssc_pkg::ERR_W-1:0] err_val;
    logic [ssc_pkg::ERR_W-1:0] err_mag;

    // Scaled error: setpoint term less the stored scaled photocell sum
    assign target_term = ssc_pkg::ERR_W'(ssc_pkg::VOLT_SCALE) * ssc_pkg::ERR_W'(target);
    assign err_val     = target_term - ssc_pkg::ERR_W'(light_scaled);
    assign err_mag     = err_val[ssc_pkg::ERR_W-1] ? (~err_val + ssc_pkg::ERR_W'(1)) : err_val;

    // Step outside the deadband; too bright closes (phase up)
    assign auto_o.step_req = err_mag > ssc_pkg::ERR_W'(error_tolerance);
    assign auto_o.step_up  = err_val[ssc_pkg::ERR_W-1];

endmodule

`default_nettype wire

/* hdl/ssc_ctrl.sv */
`default_nettype none

module ssc_ctrl #(
    parameter int CURSOR_COLS  = ssc_pkg::COLS_DEF,
    parameter int CURSOR_ROWS  = ssc_pkg::ROWS_DEF,
    parameter int SETPOINT_MAX = ssc_pkg::SETPOINT_MAX_DEF,
    parameter int PHASE_COUNT  = ssc_pkg::PHASE_COUNT_DEF
) (
    input  wire ssc_pkg::item_t  item,
    input  wire ssc_pkg::cfg_t   cfg,
    input  wire ssc_pkg::state_t st,
    output ssc_pkg::state_t      st_next,
    output ssc_pkg::flags_t      flags
);

    localparam logic [ssc_pkg::COL_W-1:0]  ColLast  = ssc_pkg::COL_W'(CURSOR_COLS - 1);
    localparam logic [ssc_pkg::ROW_W-1:0]  RowLast  = ssc_pkg::ROW_W'(CURSOR_ROWS - 1);
    localparam logic [ssc_pkg::VOLT_W-1:0] VoltMax  = ssc_pkg::VOLT_W'(SETPOINT_MAX);
    localparam logic [ssc_pkg::PH_W-1:0]   PhaseTop = ssc_pkg::PH_W'(PHASE_COUNT - 1);

    ssc_pkg::auto_t auto_s;

    logic                      pressed;
    logic                      db_idle;
    logic                      jx_high, jx_low, jy_high, jy_low;
    logic [ssc_pkg::COL_W-1:0] col_n;
    logic [ssc_pkg::ROW_W-1:0] row_n;
    logic                      jog_step, jog_up;
    logic                      do_step, step_up;

    ssc_auto u_auto (
        .target          (st.target),
        .light_scaled    (st.light_scaled),
        .error_tolerance (cfg.error_tolerance),
        .auto_o          (auto_s)
    );

    assign pressed = (item.click_level == 8'd0);
    assign db_idle = (st.db_count == '0);
    assign jx_high = item.joy_x > cfg.high_lean;
    assign jx_low  = item.joy_x < cfg.low_lean;
    assign jy_high = item.joy_y > cfg.high_lean;
    assign jy_low  = item.joy_y < cfg.low_lean;

    // Cursor candidate, saturating at the screen edges
    always_comb begin
        col_n = st.col;
        if (jx_high && st.col < ColLast) begin
            col_n = st.col + ssc_pkg::COL_W'(1);
        end else if (jx_low && st.col != '0) begin
            col_n = st.col - ssc_pkg::COL_W'(1);
        end
        row_n = st.row;
        if (jy_high && st.row < RowLast) begin
            row_n = st.row + ssc_pkg::ROW_W'(1);
        end else if (jy_low && st.row != '0) begin
            row_n = st.row - ssc_pkg::ROW_W'(1);
        end
    end

    // Screen handling for one word
    always_comb begin
        st_next  = st;
        flags    = '0;
        jog_step = 1'b0;
        jog_up   = 1'b0;
        if (!item.cmd) begin
            // tick: count the debounce timer down
            if (!db_idle) begin
                st_next.db_count = st.db_count - ssc_pkg::DB_W'(1);
            end
        end else begin
            unique case (st.screen)
                ssc_pkg::SCR_MENU: begin
                    if (db_idle) begin
                        if (col_n != st.col || row_n != st.row) begin
                            st_next.col      = col_n;
                            st_next.row      = row_n;
                            st_next.db_count = cfg.debounce_ticks;
                            flags.moved      = 1'b1;
                        end else if (pressed) begin
                            st_next.db_count = cfg.debounce_ticks;
                            if (st.col == ssc_pkg::COL_W'(ssc_pkg::MODE_COL) &&
                                st.row == ssc_pkg::ROW_W'(ssc_pkg::MODE_ROW)) begin
                                st_next.auto_mode = ~st.auto_mode;
                                flags.clr         = 1'b1;
                            end else if (st.col == ssc_pkg::COL_W'(ssc_pkg::ADJ_COL) &&
                                         st.row == ssc_pkg::ROW_W'(ssc_pkg::ADJ_ROW)) begin
                                st_next.screen = st.auto_mode ? ssc_pkg::SCR_EDIT
                                                              : ssc_pkg::SCR_JOG;
                                flags.clr      = 1'b1;
                            end
                        end
                    end
                end
                ssc_pkg::SCR_JOG: begin
                    if (pressed && db_idle) begin
                        st_next.db_count = cfg.debounce_ticks;
                        st_next.screen   = ssc_pkg::SCR_MENU;
                        flags.clr        = 1'b1;
                    end else if (jy_high) begin
                        jog_step = 1'b1;
                    end else if (jy_low) begin
                        jog_step = 1'b1;
                        jog_up   = 1'b1;
                    end
                end
                ssc_pkg::SCR_EDIT: begin
                    if (db_idle) begin
                        if (pressed) begin
                            st_next.db_count = cfg.debounce_ticks;
                            st_next.screen   = ssc_pkg::SCR_MENU;
                            flags.clr        = 1'b1;
                        end else if (jx_high) begin
                            if (st.target < VoltMax) begin
                                st_next.target = st.target + ssc_pkg::VOLT_W'(1);
                            end
                            st_next.db_count = cfg.debounce_ticks;
                        end else if (jx_low) begin
                            if (st.target != '0) begin
                                st_next.target = st.target - ssc_pkg::VOLT_W'(1);
                            end
                            st_next.db_count = cfg.debounce_ticks;
                        end
                    end
                end
                default: begin
                end
            endcase

            // latch a fresh photocell sum, pre-scaled for the error test
            if (item.light_valid) begin
                st_next.light_scaled =
                    ssc_pkg::SCALED_W'(item.light_sum) * ssc_pkg::SCALED_W'(ssc_pkg::LIGHT_SCALE);
            end
        end

        // Jog step, or automatic tracking on the menu screen
        do_step = jog_step;
        step_up = jog_up;
        if (item.cmd && st_next.auto_mode && st_next.screen == ssc_pkg::SCR_MENU &&
            auto_s.step_req) begin
            do_step = 1'b1;
            step_up = auto_s.step_up;
        end

        // Advance the phase ring
        if (do_step) begin
            flags.stepped   = 1'b1;
            st_next.coil_on = 1'b1;
            if (step_up) begin
                st_next.phase = (st.phase >= PhaseTop) ? '0 : st.phase + ssc_pkg::PH_W'(1);
            end else begin
                st_next.phase = (st.phase == '0) ? PhaseTop : st.phase - ssc_pkg::PH_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/shade_stepper_controller_core.sv */
`default_nettype none

// Shade stepper controller.
// Input channel (s_*): one word per item; s_cmd = 0 is a debounce tick,
// s_cmd = 1 a control pass with joystick, click and an optional photocell sum.
// Result channel (m_*): exactly one word per accepted item, in order, carrying
// coil drive, step flag, mode, screen, cursor, setpoint and display events.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 debounce
// reload, 1 high lean, 2 low lean, 3 error tolerance); other indexes are ignored.
// Write registers only while no item is in flight.
// Flow: an accepted item is held in the input register, processed by the control
// pass, and its result is then held in the result register that drives m_*.
// Throughput: one item per cycle while results are taken, set by the single
// control pass between the input register and the result register.
// Reset (aresetn low, synchronous): menu screen, manual mode, cursor home,
// setpoint 0, coils off, registers at their defaults, both channels empty.
// A stalled receiver holds the result word; one more item waits in the input
// register and s_ready drops until the result is taken.

module shade_stepper_controller_core #(
    parameter int CURSOR_COLS  = ssc_pkg::COLS_DEF,
    parameter int CURSOR_ROWS  = ssc_pkg::ROWS_DEF,
    parameter int SETPOINT_MAX = ssc_pkg::SETPOINT_MAX_DEF,
    parameter int PHASE_COUNT  = ssc_pkg::PHASE_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_cmd,
    input  wire logic [7:0]                       s_joy_x,
    input  wire logic [7:0]                       s_joy_y,
    input  wire logic [7:0]                       s_click_level,
    input  wire logic [ssc_pkg::LIGHT_W-1:0]      s_light_sum,
    input  wire logic                             s_light_valid,
    // result channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [3:0]                            m_coil_pattern,
    output logic                                  m_stepped,
    output logic                                  m_mode_auto,
    output logic [1:0]                            m_screen_mode,
    output logic [3:0]                            m_cursor_col,
    output logic                                  m_cursor_line,
    output logic [2:0]                            m_setpoint_volts,
    output logic                                  m_cursor_moved,
    output logic                                  m_screen_clear
);

    ssc_pkg::cfg_t   cfg_reg;
    ssc_pkg::item_t  in_item_reg;
    logic            in_valid_reg;
    ssc_pkg::state_t st_reg;
    ssc_pkg::state_t st_next;
    ssc_pkg::flags_t flags;
    logic            proc_en;
    logic [3:0]      coil_next;

    logic            m_valid_reg;
    logic [3:0]      coil_reg;
    logic            stepped_reg;
    logic            auto_reg;
    logic [1:0]      screen_reg;
    logic [3:0]      col_reg;
    logic            line_reg;
    logic [2:0]      volts_reg;
    logic            moved_reg;
    logic            clr_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks  <= ssc_pkg::DEBOUNCE_RST;
            cfg_reg.high_lean       <= ssc_pkg::HIGH_LEAN_RST;
            cfg_reg.low_lean        <= ssc_pkg::LOW_LEAN_RST;
            cfg_reg.error_tolerance <= ssc_pkg::TOL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ssc_pkg::REG_DEBOUNCE_TICKS:  cfg_reg.debounce_ticks  <= cfg_data;
                ssc_pkg::REG_HIGH_LEAN:       cfg_reg.high_lean       <= cfg_data[7:0];
                ssc_pkg::REG_LOW_LEAN:        cfg_reg.low_lean        <= cfg_data[7:0];
                ssc_pkg::REG_ERROR_TOLERANCE: cfg_reg.error_tolerance <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake: process when the result slot is free or being emptied
    assign proc_en = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_en;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.cmd         <= s_cmd;
            in_item_reg.joy_x       <= s_joy_x;
            in_item_reg.joy_y       <= s_joy_y;
            in_item_reg.click_level <= s_click_level;
            in_item_reg.light_sum   <= s_light_sum;
            in_item_reg.light_valid <= s_light_valid;
        end
    end

    ssc_ctrl #(
        .CURSOR_COLS  (CURSOR_COLS),
        .CURSOR_ROWS  (CURSOR_ROWS),
        .SETPOINT_MAX (SETPOINT_MAX),
        .PHASE_COUNT  (PHASE_COUNT)
    ) u_ctrl (
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .st_next (st_next),
        .flags   (flags)
    );

    // Controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.screen       <= ssc_pkg::SCR_MENU;
            st_reg.auto_mode    <= 1'b0;
            st_reg.col          <= '0;
            st_reg.row          <= '0;
            st_reg.target       <= '0;
            st_reg.db_count     <= '0;
            st_reg.phase        <= '0;
            st_reg.coil_on      <= 1'b0;
            st_reg.light_scaled <= '0;
        end else if (proc_en) begin
            st_reg <= st_next;
        end
    end

    // Coil drive: the active phase, dropped when it lies beyond the field
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            coil_next[i] = st_next.coil_on && (st_next.phase == ssc_pkg::PH_W'(i));
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en) begin
            coil_reg    <= coil_next;
            stepped_reg <= flags.stepped;
            auto_reg    <= st_next.auto_mode;
            screen_reg  <= ssc_pkg::screen_code(st_next.screen);
            col_reg     <= 4'(st_next.col);
            line_reg    <= st_next.row[0];
            volts_reg   <= st_next.target;
            moved_reg   <= flags.moved;
            clr_reg     <= flags.clr;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_coil_pattern   = coil_reg;
    assign m_stepped        = stepped_reg;
    assign m_mode_auto      = auto_reg;
    assign m_screen_mode    = screen_reg;
    assign m_cursor_col     = col_reg;
    assign m_cursor_line    = line_reg;
    assign m_setpoint_volts = volts_reg;
    assign m_cursor_moved   = moved_reg;
    assign m_screen_clear   = clr_reg;

    // At most one coil is driven
    a_coil_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_coil_pattern))
        else $error("coil drive has more than one phase active");

    // A tick never steps, moves the cursor or clears the screen
    a_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && !in_item_reg.cmd) |=> !(m_stepped || m_cursor_moved || m_screen_clear))
        else $error("tick word produced an event");

    // Jog screen is only reachable in manual mode
    a_jog_manual: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_screen_mode == ssc_pkg::SCREEN_CODE_JOG) |-> !m_mode_auto)
        else $error("jog screen shown in auto mode");

    // A step always leaves the coils energised on motors of at most four phases
    a_step_coil: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stepped && PHASE_COUNT <= 4) |-> (m_coil_pattern != 4'd0))
        else $error("step taken with coils off");

endmodule

`default_nettype wire
